@@ rtl/bra_pkg.sv @@
// Shared constants, codes and a helper function for the bitmap run allocator.
package bra_pkg;

    localparam int MAP_BITS  = 1024;
    localparam int WORD_BITS = 32;
    localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW   = $clog2(MAP_WORDS);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int IDX_W     = 10;
    localparam int LEN_W     = 11;
    localparam int FUNC_W    = 2;
    localparam int STAT_W    = 2;
    localparam int IN_W      = FUNC_W + IDX_W + LEN_W + 1;
    localparam int IN_TW     = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W     = STAT_W + IDX_W;
    localparam int OUT_TW    = ((OUT_W + 7) / 8) * 8;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [WORD_AW-1:0]   t_waddr;

    typedef enum logic [FUNC_W-1:0] {
        FN_FIND  = 2'd0,
        FN_CHECK = 2'd1,
        FN_WRITE = 2'd2,
        FN_NOP   = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_MISS    = 2'd1,
        ST_BLOCKED = 2'd2,
        ST_RSVD    = 2'd3
    } t_status;

    // lowest set bit position of a word
    function automatic logic [BIT_W-1:0] ffs(input t_word w);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (w[i]) begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

@@ rtl/bra_map_ram.sv @@
// Bitmap word store: one write port, one registered read port, per-word valid bits.
module bra_map_ram (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bra_pkg::t_waddr i_rd_addr,
    output bra_pkg::t_word  o_rd_data,
    input  logic            i_wr_en,
    input  bra_pkg::t_waddr i_wr_addr,
    input  bra_pkg::t_word  i_wr_data
);
    import bra_pkg::*;

    t_word                r_mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] r_vld;
    t_word                r_rd_data;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[i_rd_addr];
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
        end
    end

    // never-written words read as free
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

@@ rtl/bitmap_run_allocator.sv @@
// Bitmap run allocator top level: request sequencer, map memory and output register.
// Sequence: an accepted request scans its range one 32-bit word per cycle (1..32 words),
//   ending at the first hit or the last word, then its result goes to the output
//   register once free; refused and empty-run requests skip the scan. A new request
//   waits until the last result is registered. Writes are read-modify-write per word.
// Reset: map reads as all free at once (per-word valid bits), map_length returns to 1024.
module bitmap_run_allocator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [bra_pkg::LEN_W-1:0]  i_cfg_data,   // map_length
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // func[1:0], start_bit[11:2], run_length[22:12], bit_value[23]
    input  logic [bra_pkg::IN_TW-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // status[1:0], bit_index[11:2], zero fill above
    output logic [bra_pkg::OUT_TW-1:0] m_axis_tdata
);
    import bra_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [LEN_W-1:0]   r_map_len;
    t_func              r_func, n_func;
    logic               r_val, n_val;
    logic [IDX_W-1:0]   r_lo, n_lo;
    logic [IDX_W-1:0]   r_hi_last, n_hi_last;
    t_waddr             r_cur_w, n_cur_w;
    t_status            r_res_status, n_res_status;
    logic [IDX_W-1:0]   r_res_idx, n_res_idx;
    logic               r_o_valid, n_o_valid;
    t_status            r_o_status, n_o_status;
    logic [IDX_W-1:0]   r_o_idx, n_o_idx;

    t_func              in_func;
    logic [IDX_W-1:0]   in_start;
    logic [LEN_W-1:0]   in_run;
    logic               in_val;
    logic [LEN_W-1:0]   eff_len;
    logic [LEN_W:0]     in_end;
    logic               in_ok;
    logic               in_scan;
    logic [LEN_W-1:0]   in_hi;
    logic [LEN_W-1:0]   in_hi_last;

    t_waddr             rd_addr;
    t_word              rd_data;
    logic               wr_en;
    t_word              wr_data;
    t_word              mask;
    t_word              hits;
    logic               sought;
    logic               accept;

    assign in_func  = t_func'(s_axis_tdata[FUNC_W-1:0]);
    assign in_start = s_axis_tdata[FUNC_W +: IDX_W];
    assign in_run   = s_axis_tdata[FUNC_W+IDX_W +: LEN_W];
    assign in_val   = s_axis_tdata[FUNC_W+IDX_W+LEN_W];

    assign eff_len  = (r_map_len > LEN_W'(MAP_BITS)) ? LEN_W'(MAP_BITS) : r_map_len;
    assign in_end   = {2'b00, in_start} + {1'b0, in_run};

    always_comb begin
        in_ok = 1'b0;
        in_hi = eff_len;
        case (in_func)
            FN_FIND: begin
                in_ok = {1'b0, in_start} < eff_len;
            end
            FN_CHECK, FN_WRITE: begin
                in_ok = in_end < {1'b0, eff_len};
                in_hi = in_end[LEN_W-1:0];
            end
            default: begin
                in_ok = 1'b0;
            end
        endcase
    end

    assign in_scan    = in_ok && ((in_func == FN_FIND) || (in_run != '0));
    assign in_hi_last = in_hi - LEN_W'(1);

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;

    // word masks for the range [lo, hi_last]
    always_comb begin
        mask = '1;
        if (r_cur_w == r_lo[IDX_W-1:BIT_W]) begin
            mask = mask & (t_word'('1) << r_lo[BIT_W-1:0]);
        end
        if (r_cur_w == r_hi_last[IDX_W-1:BIT_W]) begin
            mask = mask & (t_word'('1) >> (~r_hi_last[BIT_W-1:0]));
        end
    end

    assign sought  = (r_func == FN_CHECK) ? ~r_val : r_val;
    assign hits    = (sought ? rd_data : ~rd_data) & mask;
    assign wr_data = r_val ? (rd_data | mask) : (rd_data & ~mask);
    assign wr_en   = (r_state == S_SCAN) && (r_func == FN_WRITE);

    always_comb begin
        rd_addr = r_cur_w;
        case (r_state)
            S_IDLE:  rd_addr = in_start[IDX_W-1:BIT_W];
            S_SCAN:  rd_addr = r_cur_w + t_waddr'(1);
            default: rd_addr = r_cur_w;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_func       = r_func;
        n_val        = r_val;
        n_lo         = r_lo;
        n_hi_last    = r_hi_last;
        n_cur_w      = r_cur_w;
        n_res_status = r_res_status;
        n_res_idx    = r_res_idx;
        n_o_valid    = r_o_valid && !m_axis_tready;
        n_o_status   = r_o_status;
        n_o_idx      = r_o_idx;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_func       = in_func;
                    n_val        = in_val;
                    n_lo         = in_start;
                    n_hi_last    = in_hi_last[IDX_W-1:0];
                    n_cur_w      = in_start[IDX_W-1:BIT_W];
                    n_res_idx    = '0;
                    n_res_status = in_ok ? ST_OK : ST_MISS;
                    n_state      = in_scan ? S_SCAN : S_OUT;
                end
            end
            S_SCAN: begin
                if ((r_func != FN_WRITE) && (hits != '0)) begin
                    n_res_status = (r_func == FN_FIND) ? ST_OK : ST_BLOCKED;
                    n_res_idx    = {r_cur_w, ffs(hits)};
                    n_state      = S_OUT;
                end else if (r_cur_w == r_hi_last[IDX_W-1:BIT_W]) begin
                    n_res_status = (r_func == FN_FIND) ? ST_MISS : ST_OK;
                    n_res_idx    = '0;
                    n_state      = S_OUT;
                end else begin
                    n_cur_w = r_cur_w + t_waddr'(1);
                end
            end
            S_OUT: begin
                if (!r_o_valid || m_axis_tready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_status;
                    n_o_idx    = r_res_idx;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_map_len <= LEN_W'(MAP_BITS);
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_map_len <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_val        <= n_val;
        r_lo         <= n_lo;
        r_hi_last    <= n_hi_last;
        r_cur_w      <= n_cur_w;
        r_res_status <= n_res_status;
        r_res_idx    <= n_res_idx;
        r_o_status   <= n_o_status;
        r_o_idx      <= n_o_idx;
    end

    bra_map_ram u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_cur_w),
        .i_wr_data (wr_data)
    );

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {{(OUT_TW-OUT_W){1'b0}}, r_o_idx, r_o_status};

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_cur_w <= r_hi_last[IDX_W-1:BIT_W]))
        else $error("scan word past end of range");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_SCAN) || (r_state == S_OUT))
        else $error("accepted request did not start");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == S_OUT))
        else $error("result presented without completion");

    a_miss_zero_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_o_status == ST_MISS)) |-> (r_o_idx == '0))
        else $error("miss result with nonzero index");

    a_write_only_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_func == FN_WRITE) && (r_state == S_SCAN))
        else $error("map written outside a write request");

endmodule
